[src/tctb_pkg.sv]
// Package for the text cell terminal buffer: grid size, operation codes,
// character constants, store write type and the cell address function.
// No dependencies; used by tctb_store and text_cell_terminal_buffer_top.
package tctb_pkg;

	// Grid geometry
	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;
	localparam int KEEP    = CELLS - COLUMNS;
	localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;

	// Stream and register widths
	localparam int OP_W       = 3;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 56;
	localparam int PADDR_W    = 3;

	// Operation codes
	localparam logic [OP_W-1:0] OP_PUT_CHAR   = 3'd0;
	localparam logic [OP_W-1:0] OP_WRITE_CELL = 3'd1;
	localparam logic [OP_W-1:0] OP_SET_CURSOR = 3'd2;
	localparam logic [OP_W-1:0] OP_CLEAR      = 3'd3;
	localparam logic [OP_W-1:0] OP_READ_CELL  = 3'd4;
	localparam logic [OP_W-1:0] OP_RENDER_ACK = 3'd5;

	// Register byte addresses
	localparam logic [PADDR_W-1:0] REG_DEFAULT_COLOR = 3'd0;

	// Character codes
	localparam logic [7:0] CODE_NEWLINE   = 8'd10;
	localparam logic [7:0] CODE_RETURN    = 8'd13;
	localparam logic [7:0] CODE_BACKSPACE = 8'd8;
	localparam logic [7:0] CODE_SPACE     = 8'd32;

	localparam logic [23:0] RESET_COLOR = 24'hFFFFFF;

	// One write into the cell store; code and color enabled separately
	typedef struct packed {
		logic              en_code;
		logic              en_color;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        code;
		logic [23:0]       color;
	} store_wr_t;

	// Linear cell index of (row, col); caller guarantees the cell is on the grid
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [7:0] row,
			input logic [7:0] col);
		logic [15:0] full;
		full = 16'(row) * 16'(COLUMNS) + 16'(col);
		return full[ADDR_W-1:0];
	endfunction

endpackage

[src/tctb_store.sv]
// Cell store: character and color memories, one write and one read port each,
// read data registered. Depends on tctb_pkg.
module tctb_store (
	input  logic                        clk,
	input  tctb_pkg::store_wr_t         wr,
	input  logic                        rd_en,
	input  logic [tctb_pkg::ADDR_W-1:0] rd_addr,
	output logic [7:0]                  rd_code,
	output logic [23:0]                 rd_color
);
	import tctb_pkg::*;

	logic [7:0]  code_mem  [CELLS];
	logic [23:0] color_mem [CELLS];

	// Character memory
	always_ff @(posedge clk) begin
		if (wr.en_code) begin
			code_mem[wr.addr] <= wr.code;
		end
		if (rd_en) begin
			rd_code <= code_mem[rd_addr];
		end
	end

	// Color memory
	always_ff @(posedge clk) begin
		if (wr.en_color) begin
			color_mem[wr.addr] <= wr.color;
		end
		if (rd_en) begin
			rd_color <= color_mem[rd_addr];
		end
	end

endmodule

[src/text_cell_terminal_buffer_top.sv]
// Text cell terminal buffer: top level with command decode, cursor, sweep
// sequencer for clear and scroll, result staging and the register port.
// Depends on tctb_pkg and tctb_store.
//
// Usage: commands enter on the s_ stream, the operation code in s_tuser and
// the operands in s_tdata. Each command yields exactly one transaction on the
// m_ stream carrying the cursor, read cell contents and the dirty flag.
// The register default_color (byte address 0 on the APB port) sets the color
// of blank cells written by clear and scroll; write it only while idle.
// Put char without scroll, write cell, set cursor, render ack and unused
// codes return straight to idle; read cell passes through a read state for
// the registered store read. Clear, and put char that scrolls, walk the whole
// store one cell per cycle through the single store port pair, then pass
// through a done state. The scroll copies each cell from one row below.
// After reset the store is filled with spaces in white; s_tready stays low
// meanwhile, APB writes are taken.
// A finished result waits in a staging register while the output register is
// stalled, so one more command is accepted before s_tready drops.
module text_cell_terminal_buffer_top (
	input  logic                             clk,
	input  logic                             arst_n,
	// Command stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [7:0] char_code, [31:8] color_in, [39:32] col_in, [47:40] row_in
	input  logic [tctb_pkg::IN_DATA_W-1:0]   s_tdata,
	// [2:0] operation
	input  logic [tctb_pkg::OP_W-1:0]        s_tuser,
	// Result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [7:0] cursor_col, [15:8] cursor_row, [23:16] cell_code,
	// [47:24] cell_color, [48] dirty, [55:49] zero
	output logic [tctb_pkg::OUT_DATA_W-1:0]  m_tdata,
	// Register port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [tctb_pkg::PADDR_W-1:0]     paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	import tctb_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_READ  = 2'd1;
	localparam logic [1:0] ST_SWEEP = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	localparam logic [7:0]        COL_LAST  = 8'(COLUMNS - 1);
	localparam logic [7:0]        ROW_LAST  = 8'(ROWS - 1);
	localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] KEEP_A    = ADDR_W'(KEEP);
	localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);

	// Control state
	logic [1:0]        state_q;
	logic [7:0]        col_q;
	logic [7:0]        line_q;
	logic              dirty_q;
	logic [23:0]       default_color_q;
	logic [ADDR_W-1:0] ptr_q;
	logic [ADDR_W-1:0] blank_from_q;
	logic              init_q;
	logic              rd_hit_q;
	logic              res_pend_q;
	logic              m_tvalid_q;

	// Sweep pipeline stage (write side of the copy)
	logic              valid_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              blank_s1;

	// Result staging and output registers
	logic [7:0]        res_col_q;
	logic [7:0]        res_row_q;
	logic [7:0]        res_code_q;
	logic [23:0]       res_color_q;
	logic              res_dirty_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// Input fields
	logic [OP_W-1:0] operation;
	logic [7:0]      char_code;
	logic [23:0]     color_in;
	logic [7:0]      col_in;
	logic [7:0]      row_in;

	logic              accept;
	logic              in_grid;
	logic [ADDR_W-1:0] at_in;
	logic              out_move;

	// Put char results
	logic [8:0]  col_inc;
	logic [7:0]  pc_col;
	logic [8:0]  pc_line;
	logic        pc_scroll;
	store_wr_t   pc_wr;

	// Store ports
	store_wr_t         wr;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        rd_code;
	logic [23:0]       rd_color;

	// Next command state
	logic [7:0]        nxt_col;
	logic [7:0]        nxt_line;
	logic              nxt_dirty;
	logic              go_sweep;
	logic              go_read;
	logic [ADDR_W-1:0] sweep_from;

	logic cfg_wr;

	assign operation = s_tuser;
	assign char_code = s_tdata[7:0];
	assign color_in  = s_tdata[31:8];
	assign col_in    = s_tdata[39:32];
	assign row_in    = s_tdata[47:40];

	assign s_tready = (state_q == ST_IDLE) && !res_pend_q;
	assign accept   = s_tvalid && s_tready;
	assign in_grid  = ({1'b0, col_in} < 9'(COLUMNS)) && ({1'b0, row_in} < 9'(ROWS));
	assign at_in    = cell_addr(row_in, col_in);

	// Put char: cursor movement and the cell it writes
	always_comb begin
		col_inc   = {1'b0, col_q} + 9'd1;
		pc_col    = col_q;
		pc_line   = {1'b0, line_q};
		pc_wr     = '0;
		pc_wr.code  = char_code;
		pc_wr.color = color_in;
		pc_wr.addr  = cell_addr(line_q, col_q);
		case (char_code)
			CODE_NEWLINE: begin
				pc_col  = '0;
				pc_line = {1'b0, line_q} + 9'd1;
			end
			CODE_RETURN: begin
				pc_col = '0;
			end
			CODE_BACKSPACE: begin
				if (col_q != '0) begin
					pc_col         = col_q - 8'd1;
					pc_wr.en_code  = 1'b1;
					pc_wr.code     = CODE_SPACE;
					pc_wr.addr     = cell_addr(line_q, col_q - 8'd1);
				end
			end
			default: begin
				pc_wr.en_code  = 1'b1;
				pc_wr.en_color = 1'b1;
				if (col_inc >= 9'(COLUMNS)) begin
					pc_col  = '0;
					pc_line = {1'b0, line_q} + 9'd1;
				end else begin
					pc_col = col_inc[7:0];
				end
			end
		endcase
		pc_scroll = pc_line >= 9'(ROWS);
	end

	// Command decode and store port selection
	always_comb begin
		wr         = '0;
		rd_en      = 1'b0;
		rd_addr    = ptr_q + COLS_A;
		nxt_col    = col_q;
		nxt_line   = line_q;
		nxt_dirty  = dirty_q;
		go_sweep   = 1'b0;
		go_read    = 1'b0;
		sweep_from = '0;

		// sweep: read one row below, write it (or a blank) back in the next cycle
		if (state_q == ST_SWEEP) begin
			rd_en = ptr_q < blank_from_q;
		end
		if (valid_s1) begin
			wr.en_code  = 1'b1;
			wr.en_color = 1'b1;
			wr.addr     = addr_s1;
			wr.code     = blank_s1 ? CODE_SPACE : rd_code;
			wr.color    = !blank_s1 ? rd_color : (init_q ? RESET_COLOR : default_color_q);
		end

		if (accept) begin
			case (operation)
				OP_PUT_CHAR: begin
					wr         = pc_wr;
					nxt_col    = pc_col;
					nxt_line   = pc_scroll ? ROW_LAST : pc_line[7:0];
					nxt_dirty  = 1'b1;
					go_sweep   = pc_scroll;
					sweep_from = KEEP_A;
				end
				OP_WRITE_CELL: begin
					if (in_grid) begin
						wr.en_code  = 1'b1;
						wr.en_color = 1'b1;
						wr.addr     = at_in;
						wr.code     = char_code;
						wr.color    = color_in;
						nxt_dirty   = 1'b1;
					end
				end
				OP_SET_CURSOR: begin
					nxt_col  = ({1'b0, col_in} < 9'(COLUMNS)) ? col_in : COL_LAST;
					nxt_line = ({1'b0, row_in} < 9'(ROWS)) ? row_in : ROW_LAST;
				end
				OP_CLEAR: begin
					nxt_col    = '0;
					nxt_line   = '0;
					nxt_dirty  = 1'b1;
					go_sweep   = 1'b1;
					sweep_from = '0;
				end
				OP_READ_CELL: begin
					rd_en   = in_grid;
					rd_addr = at_in;
					go_read = 1'b1;
				end
				OP_RENDER_ACK: begin
					nxt_dirty = 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	tctb_store u_store (
		.clk      (clk),
		.wr       (wr),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_code  (rd_code),
		.rd_color (rd_color)
	);

	assign out_move = res_pend_q && (!m_tvalid_q || m_tready);

	// Sequencer, cursor and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			col_q        <= '0;
			line_q       <= '0;
			dirty_q      <= 1'b1;
			ptr_q        <= '0;
			blank_from_q <= '0;
			init_q       <= 1'b1;
			rd_hit_q     <= 1'b0;
			res_pend_q   <= 1'b0;
			valid_s1     <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_SWEEP);
			if (out_move) begin
				res_pend_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						col_q    <= nxt_col;
						line_q   <= nxt_line;
						dirty_q  <= nxt_dirty;
						rd_hit_q <= in_grid;
						if (go_sweep) begin
							state_q      <= ST_SWEEP;
							ptr_q        <= '0;
							blank_from_q <= sweep_from;
						end else if (go_read) begin
							state_q <= ST_READ;
						end else begin
							res_pend_q <= 1'b1;
						end
					end
				end
				ST_READ: begin
					res_pend_q <= 1'b1;
					state_q    <= ST_IDLE;
				end
				ST_SWEEP: begin
					if (ptr_q == CELL_LAST) begin
						state_q <= ST_DONE;
					end else begin
						ptr_q <= ptr_q + ADDR_W'(1);
					end
				end
				ST_DONE: begin
					if (!init_q) begin
						res_pend_q <= 1'b1;
					end
					init_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Sweep stage payload
	always_ff @(posedge clk) begin
		addr_s1  <= ptr_q;
		blank_s1 <= ptr_q >= blank_from_q;
	end

	// Result staging payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_col_q   <= nxt_col;
			res_row_q   <= nxt_line;
			res_dirty_q <= nxt_dirty;
			res_code_q  <= '0;
			res_color_q <= '0;
		end else if (state_q == ST_READ && rd_hit_q) begin
			res_code_q  <= rd_code;
			res_color_q <= rd_color;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_move) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_move) begin
			out_data_q <= {7'd0, res_dirty_q, res_color_q, res_code_q, res_row_q, res_col_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_data_q;

	// Register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_DEFAULT_COLOR);
	assign prdata = (paddr == REG_DEFAULT_COLOR) ? {8'd0, default_color_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_color_q <= RESET_COLOR;
		end else if (cfg_wr) begin
			default_color_q <= pwdata[23:0];
		end
	end

endmodule
